>>> rtl/hsv_to_rgb_dimmed_assert.svh
// Assertion macros shared by the checker of the HSV to RGB converter.
// Needs clk and rst_n in the scope of each use.
`ifndef HSV_TO_RGB_DIMMED_ASSERT_SVH
`define HSV_TO_RGB_DIMMED_ASSERT_SVH

// same-cycle implication, off during reset
`define HRD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define HRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hsvrgb_pkg.sv
// Shared constants for the HSV to RGB converter: dimming curve, hue sectors,
// reciprocal constant. No dependencies.
package hsvrgb_pkg;

  localparam logic [8:0] HUE_WRAP = 9'd360;
  localparam logic [5:0] SECT_DEGREES = 6'd60;

  // 2185 / 32768 approximates 1/15, exact for dividends below 3826
  localparam logic [11:0] RECIP_15 = 12'd2185;

  // hue sectors of 60 degrees
  localparam logic [2:0] SECT_RED_GREEN_UP   = 3'd0;
  localparam logic [2:0] SECT_RED_DOWN       = 3'd1;
  localparam logic [2:0] SECT_BLUE_UP        = 3'd2;
  localparam logic [2:0] SECT_GREEN_DOWN     = 3'd3;
  localparam logic [2:0] SECT_RED_UP         = 3'd4;
  localparam logic [2:0] SECT_BLUE_DOWN      = 3'd5;
  localparam int unsigned NUM_SECTORS = 6;

  localparam logic [8:0] SECT_START [NUM_SECTORS] = '{
    9'd0, 9'd60, 9'd120, 9'd180, 9'd240, 9'd300
  };

  localparam logic [7:0] DIM_TABLE [256] = '{
    8'd0, 8'd1, 8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
    8'd2, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3,
    8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd4,
    8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4,
    8'd4, 8'd4, 8'd4, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5,
    8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd6, 8'd6, 8'd6,
    8'd6, 8'd6, 8'd6, 8'd6, 8'd6, 8'd7, 8'd7, 8'd7,
    8'd7, 8'd7, 8'd7, 8'd7, 8'd8, 8'd8, 8'd8, 8'd8,
    8'd8, 8'd8, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9,
    8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd11, 8'd11, 8'd11,
    8'd11, 8'd11, 8'd12, 8'd12, 8'd12, 8'd12, 8'd12, 8'd13,
    8'd13, 8'd13, 8'd13, 8'd14, 8'd14, 8'd14, 8'd14, 8'd15,
    8'd15, 8'd15, 8'd16, 8'd16, 8'd16, 8'd16, 8'd17, 8'd17,
    8'd17, 8'd18, 8'd18, 8'd18, 8'd19, 8'd19, 8'd19, 8'd20,
    8'd20, 8'd20, 8'd21, 8'd21, 8'd22, 8'd22, 8'd22, 8'd23,
    8'd23, 8'd24, 8'd24, 8'd25, 8'd25, 8'd25, 8'd26, 8'd26,
    8'd27, 8'd27, 8'd28, 8'd28, 8'd29, 8'd29, 8'd30, 8'd30,
    8'd31, 8'd32, 8'd32, 8'd33, 8'd33, 8'd34, 8'd35, 8'd35,
    8'd36, 8'd36, 8'd37, 8'd38, 8'd38, 8'd39, 8'd40, 8'd40,
    8'd41, 8'd42, 8'd43, 8'd43, 8'd44, 8'd45, 8'd46, 8'd47,
    8'd48, 8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54,
    8'd55, 8'd56, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62,
    8'd63, 8'd64, 8'd65, 8'd66, 8'd68, 8'd69, 8'd70, 8'd71,
    8'd73, 8'd74, 8'd75, 8'd76, 8'd78, 8'd79, 8'd81, 8'd82,
    8'd83, 8'd85, 8'd86, 8'd88, 8'd90, 8'd91, 8'd93, 8'd94,
    8'd96, 8'd98, 8'd99, 8'd101, 8'd103, 8'd105, 8'd107, 8'd109,
    8'd110, 8'd112, 8'd114, 8'd116, 8'd118, 8'd121, 8'd123, 8'd125,
    8'd127, 8'd129, 8'd132, 8'd134, 8'd136, 8'd139, 8'd141, 8'd144,
    8'd146, 8'd149, 8'd151, 8'd154, 8'd157, 8'd159, 8'd162, 8'd165,
    8'd168, 8'd171, 8'd174, 8'd177, 8'd180, 8'd183, 8'd186, 8'd190,
    8'd193, 8'd196, 8'd200, 8'd203, 8'd207, 8'd211, 8'd214, 8'd218,
    8'd222, 8'd226, 8'd230, 8'd234, 8'd238, 8'd242, 8'd248, 8'd255
  };

endpackage

>>> rtl/hsvrgb_div60.sv
// Divide a ramp product (at most 255 * 60) by 60 with a reciprocal multiply.
// Uses RECIP_15 from hsvrgb_pkg.
module hsvrgb_div60 (
  input  logic [13:0] dividend,
  output logic [7:0]  quotient
);
  import hsvrgb_pkg::*;

  logic [11:0] quarter;
  logic [23:0] scaled;

  // x / 60 = (x / 4) / 15; the reciprocal is exact over the whole range
  assign quarter  = dividend[13:2];
  assign scaled   = 24'(quarter) * 24'(RECIP_15);
  assign quotient = scaled[22:15];

endmodule

>>> rtl/hsv_to_rgb_dimmed.sv
// HSV to RGB converter with perceptual dimming curve, five register stages.
// A request passes stages 1 to 4 and the output stage to out_*; stalls can hold it.
// Throughput: one request per cycle unless stalled; each stage moves on when the next has room.
// Reset (rst_n low, synchronous): all stage valid bits and out_valid clear.
// Depends on hsvrgb_pkg and hsvrgb_div60.
module hsv_to_rgb_dimmed (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [8:0] in_hue_degrees,
  input  logic [7:0] in_saturation,
  input  logic [7:0] in_brightness,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);
  import hsvrgb_pkg::*;

  // stage ready chain
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;

  // stage 1: wrapped hue, dimmed value and saturation
  logic       s1_valid_r;
  logic [8:0] s1_hue_r, s1_hue_nxt;
  logic [7:0] s1_val_r, s1_val_nxt;
  logic [7:0] s1_sat_r, s1_sat_nxt;

  // stage 2: floor level, sector and offset
  logic        s2_valid_r;
  logic [7:0]  s2_val_r;
  logic [7:0]  s2_floor_r, s2_floor_nxt;
  logic [2:0]  s2_sect_r, s2_sect_nxt;
  logic [5:0]  s2_off_r, s2_off_nxt;
  logic        s2_gray_r, s2_gray_nxt;
  logic [15:0] floor_prod;
  logic [8:0]  off_full;

  // stage 3: ramp products
  logic        s3_valid_r;
  logic [7:0]  s3_val_r, s3_floor_r;
  logic [2:0]  s3_sect_r;
  logic        s3_gray_r;
  logic [13:0] s3_up_prod_r, s3_up_prod_nxt;
  logic [13:0] s3_dn_prod_r, s3_dn_prod_nxt;
  logic [7:0]  span;

  // stage 4: ramp quotients
  logic       s4_valid_r;
  logic [7:0] s4_val_r, s4_floor_r;
  logic [2:0] s4_sect_r;
  logic       s4_gray_r;
  logic [7:0] s4_up_r, s4_up_nxt;
  logic [7:0] s4_dn_r, s4_dn_nxt;

  // output stage
  logic       out_valid_r;
  logic [7:0] red_r, red_nxt;
  logic [7:0] green_r, green_nxt;
  logic [7:0] blue_r, blue_nxt;
  logic [8:0] up_sum, dn_sum;
  logic [7:0] up_lvl, dn_lvl;

  assign rdy_out  = !out_valid_r || !out_stall;
  assign rdy4     = !s4_valid_r || rdy_out;
  assign rdy3     = !s3_valid_r || rdy4;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_valid_r <= in_valid;
      if (rdy2) s2_valid_r <= s1_valid_r;
      if (rdy3) s3_valid_r <= s2_valid_r;
      if (rdy4) s4_valid_r <= s3_valid_r;
      if (rdy_out) out_valid_r <= s4_valid_r;
    end
  end

  // stage 1 logic
  always_comb begin
    s1_hue_nxt = (in_hue_degrees >= HUE_WRAP) ? (in_hue_degrees - HUE_WRAP) : in_hue_degrees;
    s1_val_nxt = DIM_TABLE[in_brightness];
    s1_sat_nxt = 8'hFF - DIM_TABLE[8'hFF - in_saturation];
  end

  // stage 2 logic
  always_comb begin
    floor_prod   = 16'(8'hFF - s1_sat_r) * 16'(s1_val_r);
    s2_floor_nxt = floor_prod[15:8];
    s2_gray_nxt  = (s1_sat_r == 8'd0);
    s2_sect_nxt  = SECT_RED_GREEN_UP;
    for (int k = 1; k < NUM_SECTORS; k++) begin
      if (s1_hue_r >= SECT_START[k]) s2_sect_nxt = 3'(k);
    end
    off_full   = s1_hue_r - SECT_START[s2_sect_nxt];
    s2_off_nxt = off_full[5:0];
  end

  // stage 3 logic
  always_comb begin
    span           = s2_val_r - s2_floor_r;
    s3_up_prod_nxt = 14'(span) * 14'(s2_off_r);
    s3_dn_prod_nxt = 14'(span) * 14'(SECT_DEGREES - s2_off_r);
  end

  // stage 4 logic
  hsvrgb_div60 u_div_up (
    .dividend (s3_up_prod_r),
    .quotient (s4_up_nxt)
  );

  hsvrgb_div60 u_div_dn (
    .dividend (s3_dn_prod_r),
    .quotient (s4_dn_nxt)
  );

  // output stage logic
  always_comb begin
    up_sum = 9'(s4_up_r) + 9'(s4_floor_r);
    dn_sum = 9'(s4_dn_r) + 9'(s4_floor_r);
    up_lvl = up_sum[7:0];
    dn_lvl = dn_sum[7:0];
    if (s4_gray_r) begin
      red_nxt   = s4_val_r;
      green_nxt = s4_val_r;
      blue_nxt  = s4_val_r;
    end else begin
      case (s4_sect_r)
        SECT_RED_GREEN_UP: begin
          red_nxt = s4_val_r;   green_nxt = up_lvl;     blue_nxt = s4_floor_r;
        end
        SECT_RED_DOWN: begin
          red_nxt = dn_lvl;     green_nxt = s4_val_r;   blue_nxt = s4_floor_r;
        end
        SECT_BLUE_UP: begin
          red_nxt = s4_floor_r; green_nxt = s4_val_r;   blue_nxt = up_lvl;
        end
        SECT_GREEN_DOWN: begin
          red_nxt = s4_floor_r; green_nxt = dn_lvl;     blue_nxt = s4_val_r;
        end
        SECT_RED_UP: begin
          red_nxt = up_lvl;     green_nxt = s4_floor_r; blue_nxt = s4_val_r;
        end
        default: begin
          red_nxt = s4_val_r;   green_nxt = s4_floor_r; blue_nxt = dn_lvl;
        end
      endcase
    end
  end

  // payload registers: hold while the next stage is full and stalled
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_hue_r <= s1_hue_nxt;
      s1_val_r <= s1_val_nxt;
      s1_sat_r <= s1_sat_nxt;
    end
    if (rdy2) begin
      s2_val_r   <= s1_val_r;
      s2_floor_r <= s2_floor_nxt;
      s2_sect_r  <= s2_sect_nxt;
      s2_off_r   <= s2_off_nxt;
      s2_gray_r  <= s2_gray_nxt;
    end
    if (rdy3) begin
      s3_val_r     <= s2_val_r;
      s3_floor_r   <= s2_floor_r;
      s3_sect_r    <= s2_sect_r;
      s3_gray_r    <= s2_gray_r;
      s3_up_prod_r <= s3_up_prod_nxt;
      s3_dn_prod_r <= s3_dn_prod_nxt;
    end
    if (rdy4) begin
      s4_val_r   <= s3_val_r;
      s4_floor_r <= s3_floor_r;
      s4_sect_r  <= s3_sect_r;
      s4_gray_r  <= s3_gray_r;
      s4_up_r    <= s4_up_nxt;
      s4_dn_r    <= s4_dn_nxt;
    end
    if (rdy_out) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

>>> rtl/hsvrgb_chk.sv
// Port-level checker for hsv_to_rgb_dimmed, bound to the top level below.
// Depends on hsv_to_rgb_dimmed_assert.svh.
`include "hsv_to_rgb_dimmed_assert.svh"

module hsvrgb_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  // a free output register must let requests through
  `HRD_ASSERT_IMPL(a_no_stall_when_drained, !out_stall, !in_stall,
                   "input stalled with output free")

  // a result appearing on an idle output came from a request that went through every stage unheld
  `HRD_ASSERT_IMPL(a_fill_latency, out_valid && !$past(out_valid),
                   $past(in_valid && !in_stall, 5), "result without matching request")

  `HRD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue),
                   "stalled result changed")

endmodule

bind hsv_to_rgb_dimmed hsvrgb_chk u_hsvrgb_chk (.*);

>>> tb/rgb_ledger_pkg.sv
// Colour prediction and result ledger for the HSV to RGB converter bench.
// Depends on hsvrgb_pkg for the hue sector codes only.
package rgb_ledger_pkg;
  import hsvrgb_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  // perceptual dimming curve, kept apart from the one in the design
  localparam logic [7:0] PERCEPT_LUT [256] = '{
    8'd0, 8'd1, 8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3,
    8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4,
    8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5,
    8'd5, 8'd5, 8'd5, 8'd6, 8'd6, 8'd6, 8'd6, 8'd6, 8'd6, 8'd6, 8'd6, 8'd7, 8'd7, 8'd7,
    8'd7, 8'd7, 8'd7, 8'd7, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd9, 8'd9, 8'd9, 8'd9,
    8'd9, 8'd9, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd11, 8'd11, 8'd11, 8'd11, 8'd11,
    8'd12, 8'd12, 8'd12, 8'd12, 8'd12, 8'd13, 8'd13, 8'd13, 8'd13, 8'd14, 8'd14, 8'd14,
    8'd14, 8'd15, 8'd15, 8'd15, 8'd16, 8'd16, 8'd16, 8'd16, 8'd17, 8'd17, 8'd17, 8'd18,
    8'd18, 8'd18, 8'd19, 8'd19, 8'd19, 8'd20, 8'd20, 8'd20, 8'd21, 8'd21, 8'd22, 8'd22,
    8'd22, 8'd23, 8'd23, 8'd24, 8'd24, 8'd25, 8'd25, 8'd25, 8'd26, 8'd26, 8'd27, 8'd27,
    8'd28, 8'd28, 8'd29, 8'd29, 8'd30, 8'd30, 8'd31, 8'd32, 8'd32, 8'd33, 8'd33, 8'd34,
    8'd35, 8'd35, 8'd36, 8'd36, 8'd37, 8'd38, 8'd38, 8'd39, 8'd40, 8'd40, 8'd41, 8'd42,
    8'd43, 8'd43, 8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd48, 8'd49, 8'd50, 8'd51, 8'd52,
    8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62, 8'd63, 8'd64,
    8'd65, 8'd66, 8'd68, 8'd69, 8'd70, 8'd71, 8'd73, 8'd74, 8'd75, 8'd76, 8'd78, 8'd79,
    8'd81, 8'd82, 8'd83, 8'd85, 8'd86, 8'd88, 8'd90, 8'd91, 8'd93, 8'd94, 8'd96, 8'd98,
    8'd99, 8'd101, 8'd103, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114, 8'd116,
    8'd118, 8'd121, 8'd123, 8'd125, 8'd127, 8'd129, 8'd132, 8'd134, 8'd136, 8'd139,
    8'd141, 8'd144, 8'd146, 8'd149, 8'd151, 8'd154, 8'd157, 8'd159, 8'd162, 8'd165,
    8'd168, 8'd171, 8'd174, 8'd177, 8'd180, 8'd183, 8'd186, 8'd190, 8'd193, 8'd196,
    8'd200, 8'd203, 8'd207, 8'd211, 8'd214, 8'd218, 8'd222, 8'd226, 8'd230, 8'd234,
    8'd238, 8'd242, 8'd248, 8'd255
  };

  function automatic colour_t hsv_dim_to_rgb(logic [8:0] hue, logic [7:0] sat,
                                             logic [7:0] bri);
    int unsigned h, v, s, lvl, span, off, up, dn;
    logic [2:0] sector;
    colour_t c;
    h = hue;
    // wrap once, so 360 lands on 0 and above it on 1..151
    if (h >= 360) h = h - 360;
    v = PERCEPT_LUT[bri];
    s = 255 - PERCEPT_LUT[8'd255 - sat];
    if (s == 0) begin
      c.red = v[7:0];
      c.green = v[7:0];
      c.blue = v[7:0];
      return c;
    end
    lvl = ((255 - s) * v) >> 8;
    span = v - lvl;
    off = h % 60;
    up = (span * off) / 60 + lvl;
    dn = (span * (60 - off)) / 60 + lvl;
    sector = 3'(h / 60);
    case (sector)
      SECT_RED_GREEN_UP: c = '{v[7:0], up[7:0], lvl[7:0]};
      SECT_RED_DOWN:     c = '{dn[7:0], v[7:0], lvl[7:0]};
      SECT_BLUE_UP:      c = '{lvl[7:0], v[7:0], up[7:0]};
      SECT_GREEN_DOWN:   c = '{lvl[7:0], dn[7:0], v[7:0]};
      SECT_RED_UP:       c = '{up[7:0], lvl[7:0], v[7:0]};
      default:           c = '{v[7:0], lvl[7:0], dn[7:0]};
    endcase
    return c;
  endfunction

  class rgb_ledger;
    colour_t rgb_due[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_request(logic [8:0] hue, logic [7:0] sat, logic [7:0] bri);
      rgb_due.push_back(hsv_dim_to_rgb(hue, sat, bri));
    endfunction

    function void check_colour(colour_t got);
      colour_t want;
      if (rgb_due.size() == 0) begin
        $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                 got.red, got.green, got.blue);
        mismatches++;
        return;
      end
      want = rgb_due.pop_front();
      if (got.red !== want.red) begin
        $display("%0t: red expected %0d, actual %0d", $time, want.red, got.red);
        mismatches++;
      end
      if (got.green !== want.green) begin
        $display("%0t: green expected %0d, actual %0d", $time, want.green, got.green);
        mismatches++;
      end
      if (got.blue !== want.blue) begin
        $display("%0t: blue expected %0d, actual %0d", $time, want.blue, got.blue);
        mismatches++;
      end
    endfunction
  endclass

endpackage

>>> tb/testbench.sv
// Bench for hsv_to_rgb_dimmed: directed corner pixels, then random pixels under
// random idling on both, one or no side. Depends on hsvrgb_pkg, rgb_ledger_pkg.
module testbench;
  import rgb_ledger_pkg::*;

  localparam int unsigned RANDOM_PIXELS = 2000;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [8:0] in_hue_degrees = '0;
  logic [7:0] in_saturation = '0;
  logic [7:0] in_brightness = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  bit          send_idles = 1'b1;
  bit          recv_idles = 1'b1;
  int unsigned cycles = 0;
  rgb_ledger   ledger = new();

  hsv_to_rgb_dimmed i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue_degrees(in_hue_degrees),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned draw_wait(bit enabled);
    return enabled ? $urandom_range(0, 5) : 0;
  endfunction

  task automatic send_pixel(logic [8:0] hue, logic [7:0] sat, logic [7:0] bri);
    int unsigned gap;
    gap = draw_wait(send_idles);
    if (gap > 0) begin
      // drop valid and scramble the idle payload
      @(negedge clk);
      in_valid <= 1'b0;
      in_hue_degrees <= 9'($urandom);
      in_saturation <= 8'($urandom);
      in_brightness <= 8'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_hue_degrees <= hue;
    in_saturation <= sat;
    in_brightness <= bri;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    ledger.note_request(hue, sat, bri);
  endtask

  task automatic send_random_pixel();
    logic [8:0] hue;
    logic [7:0] sat, bri;
    case ($urandom_range(0, 15))
      0:       hue = 9'd360;
      1, 2:    hue = 9'($urandom_range(361, 511));
      default: hue = 9'($urandom_range(0, 359));
    endcase
    case ($urandom_range(0, 7))
      0:       sat = 8'd0;
      1:       sat = 8'd255;
      default: sat = 8'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       bri = 8'd0;
      1:       bri = 8'd255;
      default: bri = 8'($urandom);
    endcase
    send_pixel(hue, sat, bri);
  endtask

  // result side: stall for a drawn number of cycles, then take one result
  initial begin
    int unsigned hold;
    wait (rst_n === 1'b1);
    forever begin
      hold = draw_wait(recv_idles);
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
      end
      forever begin
        @(posedge clk);
        if (out_valid === 1'b1 && !out_stall) break;
      end
      ledger.check_colour('{out_red, out_green, out_blue});
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // sector edges at full colour
    send_pixel(9'd0, 8'd255, 8'd255);
    send_pixel(9'd59, 8'd255, 8'd255);
    send_pixel(9'd60, 8'd255, 8'd255);
    send_pixel(9'd119, 8'd255, 8'd255);
    send_pixel(9'd120, 8'd255, 8'd255);
    send_pixel(9'd179, 8'd255, 8'd255);
    send_pixel(9'd180, 8'd255, 8'd255);
    send_pixel(9'd239, 8'd255, 8'd255);
    send_pixel(9'd240, 8'd255, 8'd255);
    send_pixel(9'd299, 8'd255, 8'd255);
    send_pixel(9'd300, 8'd255, 8'd255);
    send_pixel(9'd359, 8'd255, 8'd255);
    // hue of 360 and the wrap above it
    send_pixel(9'd360, 8'd255, 8'd255);
    send_pixel(9'd361, 8'd200, 8'd200);
    send_pixel(9'd511, 8'd255, 8'd255);
    send_pixel(9'd420, 8'd85, 8'd170);
    // gray pixels, hue ignored
    send_pixel(9'd90, 8'd0, 8'd200);
    send_pixel(9'd511, 8'd0, 8'd255);
    send_pixel(9'd0, 8'd0, 8'd0);
    // extremes of saturation and brightness, then one mid-range pixel
    send_pixel(9'd200, 8'd1, 8'd255);
    send_pixel(9'd30, 8'd255, 8'd0);
    send_pixel(9'd150, 8'd254, 8'd1);
    send_pixel(9'd270, 8'd2, 8'd254);
    send_pixel(9'd330, 8'd127, 8'd64);

    // four phases: both sides idle, neither, sender only, receiver only
    for (int unsigned n = 0; n < RANDOM_PIXELS; n++) begin
      case (n / (RANDOM_PIXELS / 4))
        0: begin send_idles = 1'b1; recv_idles = 1'b1; end
        1: begin send_idles = 1'b0; recv_idles = 1'b0; end
        2: begin send_idles = 1'b1; recv_idles = 1'b0; end
        default: begin send_idles = 1'b0; recv_idles = 1'b1; end
      endcase
      send_random_pixel();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (ledger.rgb_due.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (20) @(posedge clk);
    if (ledger.mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
